// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/smf_pkg.sv =====
// Package for the substring match finder: constants, register codes, types, folding.
// No dependencies.
package smf_pkg;

  localparam int BYTE_W          = 8;
  localparam int NEEDLE_BYTES    = 16;
  localparam int NB_IDX_W        = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int NLEN_W          = 5;
  localparam int OVL_W           = 4;
  localparam int OUT_OFS_W       = 32;
  localparam int OUT_DATA_W      = 2 * OUT_OFS_W;
  localparam int DEF_MAX_NEEDLE  = 16;
  localparam int DEF_OFFSET_BITS = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LOW  = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LEN  = 2'd2,
    REG_MATCH_CASE  = 2'd3
  } cfg_reg_e;

  typedef logic [NEEDLE_BYTES-1:0][BYTE_W-1:0] needle_t;

  typedef struct packed {
    needle_t needle;
    logic    match_case;
  } cfg_t;

  // Fold ASCII upper case to lower unless exact compare is selected
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b,
                                             input logic match_case);
    logic [BYTE_W-1:0] r;
    r = b;
    if (!match_case && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/substring_match_finder_top.sv =====
// Top level of the substring match finder: config registers, line state,
// cell chain and output queue. Depends on smf_pkg, smf_cell, smf_out_buf.
//
// Usage:
//   Input channel s_axis_*: one item per text byte (tdata[7:0]) or one
//   line-end item (tuser[0] = 1) standing for the newline after a line.
//   Output channel m_axis_*: one item per match, tdata[31:0] start offset,
//   tdata[63:32] end offset (one past the last byte) in the joined text.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 needle bytes 0-7, 1 needle bytes 8-15, 2 needle length, 3 match case);
//   write only while the block is idle.
// Throughput: one input item per cycle while the output queue is not full; the needle
//   compare across the MAX_NEEDLE window cells completes in the cycle the item is accepted.
// Output: a match enters the output queue when its last byte is accepted, then is offered on m_axis.
// Stall: a two-entry output queue holds results; s_axis_tready drops only
//   when both entries are full, so input keeps flowing during short stalls.
// Reset: offset, line fill and overlap block clear, needle length is zero
//   (matching off), match case is set, and the output queue empties.
module substring_match_finder_top #(
  parameter int MAX_NEEDLE  = smf_pkg::DEF_MAX_NEEDLE,
  parameter int OFFSET_BITS = smf_pkg::DEF_OFFSET_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]                    s_axis_tuser,   // [0] line_end
  // Output channel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [smf_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] start_offset, [63:32] end_offset
  // Configuration port
  input  logic                          cfg_we_i,
  input  logic [smf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import smf_pkg::*;

  localparam int FILL_W = $clog2(MAX_NEEDLE + 1);
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

  // Configuration registers
  logic [CFG_DATA_W-1:0] needle_lo_q, needle_hi_q;
  logic [NLEN_W-1:0]     needle_len_q;
  logic                  match_case_q;
  cfg_t                  cfg;

  // Line state
  logic [OFFSET_BITS-1:0] ofs_q, ofs_d;
  logic [FILL_W-1:0]      fill_q, fill_d, fill_n;
  logic [OVL_W-1:0]       ovl_q, ovl_d;

  logic                   accept, line_end, hit, all_match;
  logic [FILL_W-1:0]      len;
  logic [OFFSET_BITS-1:0] start_ofs, end_ofs, len_m1;
  logic [OFFSET_BITS+OUT_OFS_W-1:0] start_ext, end_ext;
  logic                   buf_full;

  logic [MAX_NEEDLE-1:0]              cell_match;
  logic [MAX_NEEDLE-1:0][BYTE_W-1:0]  win;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q  <= '0;
      needle_hi_q  <= '0;
      needle_len_q <= '0;
      match_case_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEEDLE_LOW:  needle_lo_q  <= cfg_data_i;
        REG_NEEDLE_HIGH: needle_hi_q  <= cfg_data_i;
        REG_NEEDLE_LEN:  needle_len_q <= cfg_data_i[NLEN_W-1:0];
        REG_MATCH_CASE:  match_case_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.needle     = needle_t'({needle_hi_q, needle_lo_q});
  assign cfg.match_case = match_case_q;

  // Needle length clamped to the window depth
  assign len = (needle_len_q > NLEN_W'(MAX_NEEDLE)) ? FILL_W'(MAX_NEEDLE)
                                                     : FILL_W'(needle_len_q);

  assign s_axis_tready = !buf_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign line_end      = s_axis_tuser[0];

  // Cell chain: cell k sees the byte k positions back in the line
  assign win[0] = s_axis_tdata;

  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
    if (k < MAX_NEEDLE - 1) begin : g_link
      smf_cell #(.IDX(k), .FILL_W(FILL_W)) u_cell (
        .clk_i   (clk_i),
        .shift_i (accept && !line_end),
        .byte_i  (win[k]),
        .byte_o  (win[k+1]),
        .cfg_i   (cfg),
        .len_i   (len),
        .match_o (cell_match[k])
      );
    end else begin : g_tail
      smf_cell #(.IDX(k), .FILL_W(FILL_W)) u_cell (
        .clk_i   (clk_i),
        .shift_i (accept && !line_end),
        .byte_i  (win[k]),
        .byte_o  (),
        .cfg_i   (cfg),
        .len_i   (len),
        .match_o (cell_match[k])
      );
    end
  end

  assign all_match = &cell_match;

  // Per-item state update and match decision
  always_comb begin
    ofs_d  = (ofs_q != OFS_MAX) ? ofs_q + OFFSET_BITS'(1) : ofs_q;
    fill_n = (fill_q < FILL_W'(MAX_NEEDLE)) ? fill_q + FILL_W'(1) : fill_q;
    fill_d = fill_n;
    ovl_d  = ovl_q;
    hit    = 1'b0;
    if (line_end) begin
      fill_d = '0;
      ovl_d  = '0;
    end else if (ovl_q != '0) begin
      ovl_d = ovl_q - OVL_W'(1);
    end else if (len != '0 && fill_n >= len && all_match) begin
      hit   = 1'b1;
      ovl_d = OVL_W'(len - FILL_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q  <= '0;
      fill_q <= '0;
      ovl_q  <= '0;
    end else if (accept) begin
      ofs_q  <= ofs_d;
      fill_q <= fill_d;
      ovl_q  <= ovl_d;
    end
  end

  // Match offsets, clamped at zero and at the offset maximum
  assign len_m1    = OFFSET_BITS'(len) - OFFSET_BITS'(1);
  assign start_ofs = (ofs_q >= len_m1) ? ofs_q - len_m1 : '0;
  assign end_ofs   = ofs_d;
  assign start_ext = {{OUT_OFS_W{1'b0}}, start_ofs};
  assign end_ext   = {{OUT_OFS_W{1'b0}}, end_ofs};

  smf_out_buf #(.W(OUT_DATA_W)) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && hit),
    .data_i  ({end_ext[OUT_OFS_W-1:0], start_ext[OUT_OFS_W-1:0]}),
    .full_o  (buf_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/smf_cell.sv =====
// One window cell: compares its byte against the matching needle byte and
// passes the byte to the next cell. Depends on smf_pkg.
module smf_cell #(
  parameter int IDX    = 0,
  parameter int FILL_W = 5
) (
  input  logic                      clk_i,
  input  logic                      shift_i,
  input  logic [smf_pkg::BYTE_W-1:0] byte_i,
  output logic [smf_pkg::BYTE_W-1:0] byte_o,
  input  smf_pkg::cfg_t             cfg_i,
  input  logic [FILL_W-1:0]         len_i,
  output logic                      match_o
);
  import smf_pkg::*;

  logic [BYTE_W-1:0]   byte_q;
  logic [NB_IDX_W-1:0] sel;
  logic                active;

  // Needle byte that lines up with this window distance
  assign active = len_i > FILL_W'(IDX);
  assign sel    = NB_IDX_W'(len_i - FILL_W'(IDX) - FILL_W'(1));

  assign match_o = !active ||
                   (fold(byte_i, cfg_i.match_case) == fold(cfg_i.needle[sel], cfg_i.match_case));

  // Window shift; stale bytes are masked by the line fill count
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== rtl/core/smf_out_buf.sv =====
// Two-entry output queue that parts the match logic from the result channel.
// No dependencies.
module smf_out_buf #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [1:0][W-1:0] mem_q;
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/smf_checker.sv =====
// Port-level checker for the substring match finder, bound to the top level.
// Depends on smf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [smf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import smf_pkg::*;

  logic [OUT_OFS_W-1:0] start_ofs, end_ofs;

  assign start_ofs = m_axis_tdata[OUT_OFS_W-1:0];
  assign end_ofs   = m_axis_tdata[OUT_DATA_W-1:OUT_OFS_W];

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // With the queue empty the input side is always open
  `ASSERT_ALWAYS(a_ready_when_empty, clk_i, rst_ni, m_axis_tvalid || s_axis_tready)

  // No result appears without an accepted input item
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready), !m_axis_tvalid)

  // A match span is ordered and no longer than NEEDLE_BYTES
  `ASSERT_ALWAYS(a_span, clk_i, rst_ni, !m_axis_tvalid || (end_ofs >= start_ofs && (end_ofs - start_ofs) <= OUT_OFS_W'(NEEDLE_BYTES)))

endmodule

bind substring_match_finder_top smf_checker u_smf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for substring_match_finder_top: directed and random text
// streams against a built-in predictor of the needle search. Depends on smf_pkg.
module tb_top;
  import smf_pkg::*;

  typedef struct packed {
    logic [31:0] end_ofs;
    logic [31:0] start_ofs;
  } match_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic [0:0]            s_axis_tuser = 1'b0;    // [0] line_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;           // [31:0] start_offset, [63:32] end_offset
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  substring_match_finder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: register copies and line/window state after reset
  logic [63:0] nd_lo = '0;
  logic [63:0] nd_hi = '0;
  logic [4:0]  nd_len = '0;
  logic        nd_exact = 1'b1;
  logic [7:0]  recent [0:14] = '{default: 8'h00};
  int          line_fill = 0;
  logic [31:0] ofs_next = '0;
  int          overlap_left = 0;

  match_t pending_matches [$];
  match_t got_match, want_match;

  // Run statistics
  int mismatches = 0;
  int items_sent = 0;
  int line_ends = 0;
  int matches_seen = 0;
  int cfg_writes = 0;
  int input_stalls = 0;

  // Sender burst control
  int burst_left = 0;
  bit gaps_off = 1'b0;

  // Receiver stall pattern and long hold-off; a toggle of hold_req asks for one
  int rx_tick = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("MISMATCH @%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic logic [7:0] needle_at(input int k);
    logic [127:0] nv;
    nv = {nd_hi, nd_lo};
    return nv[8*k +: 8];
  endfunction

  function automatic logic [7:0] cmp_byte(input logic [7:0] c);
    return (!nd_exact && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= 8'h61 && l <= 8'h7A) ? (c ^ 8'h20) : c;
  endfunction

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h41;
      2: return 8'h62;
      default: return 8'h42;
    endcase
  endfunction

  // Advance the predicted search by one item; returns 1 when a match completes
  function automatic bit scan_byte(input logic [7:0] b, input bit lend, output match_t m);
    logic [31:0] cur;
    logic [7:0]  wb;
    int          len, i;
    bit          hit;
    cur = ofs_next;
    hit = 1'b0;
    m = '0;
    if (ofs_next != '1) ofs_next++;
    if (lend) begin
      recent = '{default: 8'h00};
      line_fill = 0;
      overlap_left = 0;
      return 1'b0;
    end
    len = (nd_len > 16) ? 16 : int'(nd_len);
    if (line_fill < 16) line_fill++;
    if (overlap_left > 0) begin
      overlap_left--;
    end else if (len > 0 && line_fill >= len) begin
      hit = 1'b1;
      for (i = 0; i < len; i++) begin
        wb = (len - 1 - i == 0) ? b : recent[len - 2 - i];
        if (cmp_byte(wb) != cmp_byte(needle_at(i))) hit = 1'b0;
      end
      if (hit) begin
        m.start_ofs = (cur >= len - 1) ? cur - (len - 1) : '0;
        m.end_ofs = (cur != '1) ? cur + 1 : cur;
        overlap_left = len - 1;
      end
    end
    for (i = 14; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = b;
    return hit;
  endfunction

  // Offer one item, with random bursts and gaps, and predict on acceptance
  task automatic send_item(input logic [7:0] b, input bit lend);
    int     gap;
    match_t m;
    if (!gaps_off && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= lend;
    do @(posedge clk_i); while (!s_axis_tready);
    if (scan_byte(b, lend, m)) pending_matches = {pending_matches, m};
    items_sent++;
    if (lend) line_ends++;
  endtask

  task automatic send_string(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_NEEDLE_LOW:  nd_lo = val;
      REG_NEEDLE_HIGH: nd_hi = val;
      REG_NEEDLE_LEN:  nd_len = val[4:0];
      REG_MATCH_CASE:  nd_exact = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Stop offering, let every predicted match drain, then allow for latency
  task automatic wait_idle();
    int waited;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (pending_matches.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_matches.size() != 0) begin
      report("matches never delivered", pending_matches.size(), 0);
      pending_matches.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Compare each delivered match with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_match = m_axis_tdata;
      if (pending_matches.size() == 0) begin
        report("unexpected match, start", got_match.start_ofs, 0);
      end else begin
        want_match = pending_matches.pop_front();
        if (got_match.start_ofs != want_match.start_ofs)
          report("start_offset", got_match.start_ofs, want_match.start_ofs);
        if (got_match.end_ofs != want_match.end_ofs)
          report("end_offset", got_match.end_ofs, want_match.end_ofs);
        matches_seen++;
      end
    end
  end

  // Receiver: rotating stall patterns, plus a long hold-off on request
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_req != hold_ack) begin
      hold_left = 300;
      hold_ack = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_tick / 128) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (rx_tick % 5 == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && !s_axis_tready) input_stalls++;
  end

  // Needle length zero out of reset: nothing may match
  task automatic test_zero_length();
    send_item(8'h61, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Exact compare from reset; overlapping second hit must be suppressed
  task automatic test_exact_nonoverlap();
    wait_idle();
    write_reg(REG_NEEDLE_LOW, 64'h0000_0000_0061_4261);   // "aBa"
    write_reg(REG_NEEDLE_LEN, 64'd3);
    send_string("aBaBa");
    send_item(8'h00, 1'b1);
  endtask

  // Case folding, then a needle change while a match span is still blocking
  task automatic test_fold_and_pending_block();
    wait_idle();
    write_reg(REG_MATCH_CASE, 64'd0);
    send_string("AbA");
    wait_idle();
    write_reg(REG_NEEDLE_LEN, 64'd1);
    send_string("aaA");
    send_item(8'hFF, 1'b1);
  endtask

  // Full 16-byte needle with extreme and fold-boundary bytes, length above max
  task automatic test_full_needle();
    logic [127:0] text;
    int           k;
    text = 128'hAA75_0A20_7F80_7B60_5A41_7A61_5B40_FF00;
    wait_idle();
    write_reg(REG_NEEDLE_LOW, 64'h7A61_5A41_5B40_FF00);
    write_reg(REG_NEEDLE_HIGH, 64'hAA55_0A20_7F80_7B60);
    write_reg(REG_NEEDLE_LEN, 64'd20);
    for (k = 0; k < 16; k++) send_item(text[8*k +: 8], 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  // Mostly needle copies with random case among letter noise and line ends
  task automatic send_random_text(input int n);
    int          sent, r, k, len, cut;
    logic [7:0]  c;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      len = (nd_len > 16) ? 16 : int'(nd_len);
      if (r < 7) begin
        c = 8'($urandom_range(0, 255));
        send_item(c, 1'b1);
        sent++;
      end else if (r < 40 && len > 0) begin
        for (k = 0; k < len; k++) begin
          c = needle_at(k);
          if ($urandom_range(0, 3) == 0) c = flip_case(c);
          send_item(c, 1'b0);
        end
        sent += len;
      end else if (r < 50 && len > 1) begin
        // broken copy: a needle prefix only
        cut = $urandom_range(1, len - 1);
        for (k = 0; k < cut; k++) send_item(needle_at(k), 1'b0);
        sent += cut;
      end else begin
        if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
        else c = pick_letter();
        send_item(c, 1'b0);
        sent++;
      end
    end
  endtask

  // Random phases; lines carry over between phases
  task automatic test_random_phases();
    logic [127:0] nv;
    logic [63:0]  rnd;
    logic [4:0]   len;
    int           p, k;
    for (p = 0; p < 10; p++) begin
      wait_idle();
      for (k = 0; k < 16; k++) begin
        if ($urandom_range(0, 4) == 0) nv[8*k +: 8] = 8'($urandom_range(0, 255));
        else nv[8*k +: 8] = pick_letter();
      end
      case (p)
        0: len = 5'd16;
        1: len = 5'($urandom_range(17, 31));
        2: len = 5'd0;
        default: len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(9, 16))
                                                   : 5'($urandom_range(1, 8));
      endcase
      write_reg(REG_NEEDLE_LOW, nv[63:0]);
      write_reg(REG_NEEDLE_HIGH, nv[127:64]);
      rnd = {$urandom, $urandom};
      write_reg(REG_NEEDLE_LEN, {rnd[63:5], len});
      rnd = {$urandom, $urandom};
      write_reg(REG_MATCH_CASE, {rnd[63:1], 1'($urandom_range(0, 1))});
      gaps_off = ($urandom_range(0, 3) == 0);
      send_random_text(45);
    end
    gaps_off = 1'b0;
  endtask

  // Receiver holds off while the sender streams single-byte hits back to back
  task automatic test_backpressure();
    int k;
    wait_idle();
    write_reg(REG_NEEDLE_LOW, 64'h61);
    write_reg(REG_NEEDLE_LEN, 64'd1);
    write_reg(REG_MATCH_CASE, 64'd1);
    send_item(8'h00, 1'b1);
    gaps_off = 1'b1;
    hold_req = !hold_req;
    for (k = 0; k < 40; k++) send_item(8'h61, 1'b0);
    gaps_off = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_length();
    test_exact_nonoverlap();
    test_fold_and_pending_block();
    test_full_needle();
    test_random_phases();
    test_backpressure();
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items (%0d line ends) over %0d register writes; %0d matches checked.",
             items_sent, line_ends, cfg_writes, matches_seen);
    $display("Input held back by output stalls for %0d cycles.", input_stalls);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout: run did not finish");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/smf_pkg.sv
rtl/core/smf_cell.sv
rtl/core/smf_out_buf.sv
rtl/core/substring_match_finder_top.sv
rtl/core/smf_checker.sv
tb/tb_top.sv
